// ----- rtl/h264pse_pkg.sv -----
// Shared types and constants of the H.264 parameter set extractor.
package h264pse_pkg;

  // Delay line depth and the most results one item can cause
  localparam int LINE_DEPTH = 5;
  localparam int NUM_CAND   = LINE_DEPTH + 1;

  // Result queue sizing
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int READY_LIMIT = FIFO_DEPTH - NUM_CAND;

  // Register reset values
  localparam logic [4:0] SPS_CODE_RESET = 5'd7;
  localparam logic [4:0] PPS_CODE_RESET = 5'd8;

  // Configuration register indexes
  localparam logic REG_SPS_CODE = 1'b0;
  localparam logic REG_PPS_CODE = 1'b1;

  // Class of a byte in the delay line
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_SPS  = 2'd1,
    CLS_PPS  = 2'd2,
    CLS_PEND = 2'd3
  } cls_t;

  typedef struct packed {
    logic first;
    cls_t cls;
  } tag_t;

  // One candidate result from the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       pps;
    logic       first;
    logic       last;
  } cand_t;

  // One queued result
  typedef struct packed {
    logic [7:0] data;
    logic       pps;
    logic       first;
    logic       last;
  } res_t;

endpackage

// ----- rtl/h264pse_parser.sv -----
// Start code detection, unit classification and the five byte delay line.
module h264pse_parser
  import h264pse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [7:0]               stream_byte,
  input  logic                     end_of_buffer,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [4:0]               cfg_data,
  output cand_t [NUM_CAND-1:0]     cand_o
);

  logic [7:0] line_byte_r [LINE_DEPTH];
  tag_t       line_tag_r  [LINE_DEPTH];
  cls_t       cur_cls_r;
  logic [1:0] zero_run_r;
  logic       pending_r;
  logic [1:0] holdoff_r;
  logic [2:0] seen_r;
  logic [4:0] sps_code_r;
  logic [4:0] pps_code_r;

  logic [7:0] line_byte_nxt [LINE_DEPTH];
  tag_t       line_tag_nxt  [LINE_DEPTH];
  tag_t       tag_a         [LINE_DEPTH];
  cls_t       cur_cls_nxt;
  cls_t       new_cls;
  logic [1:0] zero_run_nxt;
  logic       pending_nxt;
  logic [1:0] holdoff_nxt;
  logic [2:0] seen_nxt;
  logic       det;
  logic       four;
  logic       retag;

  // Detect a start code and classify the type byte
  always_comb begin
    det   = (stream_byte == 8'd1) && (zero_run_r >= 2'd2) && (holdoff_r == 2'd0);
    four  = det && (zero_run_r == 2'd3);
    retag = !det && pending_r;
    if (stream_byte[4:0] == sps_code_r) begin
      new_cls = CLS_SPS;
    end else if (stream_byte[4:0] == pps_code_r) begin
      new_cls = CLS_PPS;
    end else begin
      new_cls = CLS_NONE;
    end
  end

  // Mark the start code bytes already in the line, then shift and retag
  always_comb begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      tag_a[i] = line_tag_r[i];
    end
    if (det) begin
      tag_a[0] = tag_t'{first: 1'b0, cls: CLS_PEND};
      tag_a[1] = tag_t'{first: !four, cls: CLS_PEND};
      if (four) begin
        tag_a[2] = tag_t'{first: 1'b1, cls: CLS_PEND};
      end
    end
    line_byte_nxt[0] = stream_byte;
    line_tag_nxt[0]  = det ? tag_t'{first: 1'b0, cls: CLS_PEND}
                           : tag_t'{first: 1'b0, cls: cur_cls_r};
    for (int i = 1; i < LINE_DEPTH; i++) begin
      line_byte_nxt[i] = line_byte_r[i-1];
      line_tag_nxt[i]  = tag_a[i-1];
    end
    if (retag) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        if (line_tag_nxt[i].cls == CLS_PEND) begin
          line_tag_nxt[i].cls = new_cls;
        end
      end
    end
  end

  // Next values of the scan state
  always_comb begin
    seen_nxt = (seen_r == 3'(LINE_DEPTH)) ? seen_r : seen_r + 3'd1;
    if (stream_byte == 8'd0) begin
      zero_run_nxt = (zero_run_r == 2'd3) ? zero_run_r : zero_run_r + 2'd1;
    end else begin
      zero_run_nxt = 2'd0;
    end
    if (det) begin
      cur_cls_nxt = CLS_PEND;
      pending_nxt = 1'b1;
      holdoff_nxt = four ? 2'd2 : 2'd3;
    end else begin
      cur_cls_nxt = retag ? new_cls : cur_cls_r;
      pending_nxt = retag ? 1'b0 : pending_r;
      holdoff_nxt = (holdoff_r != 2'd0) ? holdoff_r - 2'd1 : 2'd0;
    end
  end

  // Build candidates: the byte leaving the line, then the flushed line
  always_comb begin
    logic later;
    later = 1'b0;
    cand_o[0].valid = (seen_r == 3'(LINE_DEPTH)) &&
                      ((line_tag_r[LINE_DEPTH-1].cls == CLS_SPS) ||
                       (line_tag_r[LINE_DEPTH-1].cls == CLS_PPS));
    cand_o[0].data  = line_byte_r[LINE_DEPTH-1];
    cand_o[0].pps   = (line_tag_r[LINE_DEPTH-1].cls == CLS_PPS);
    cand_o[0].first = line_tag_r[LINE_DEPTH-1].first;
    cand_o[0].last  = 1'b0;
    for (int k = 1; k < NUM_CAND; k++) begin
      cand_o[k].valid = end_of_buffer && (3'(LINE_DEPTH - k) < seen_nxt) &&
                        ((line_tag_nxt[LINE_DEPTH-k].cls == CLS_SPS) ||
                         (line_tag_nxt[LINE_DEPTH-k].cls == CLS_PPS));
      cand_o[k].data  = line_byte_nxt[LINE_DEPTH-k];
      cand_o[k].pps   = (line_tag_nxt[LINE_DEPTH-k].cls == CLS_PPS);
      cand_o[k].first = line_tag_nxt[LINE_DEPTH-k].first;
      cand_o[k].last  = 1'b0;
    end
    // Flag the final valid candidate
    for (int k = NUM_CAND - 1; k >= 0; k--) begin
      cand_o[k].last = cand_o[k].valid && !later;
      later = later || cand_o[k].valid;
    end
  end

  // Advance the scan state on each item; end of buffer clears it
  always_ff @(posedge clk) begin
    if (!rst_n || (take && end_of_buffer)) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_byte_r[i] <= 8'd0;
        line_tag_r[i]  <= tag_t'{first: 1'b0, cls: CLS_NONE};
      end
      cur_cls_r  <= CLS_NONE;
      zero_run_r <= 2'd0;
      pending_r  <= 1'b0;
      holdoff_r  <= 2'd0;
      seen_r     <= 3'd0;
    end else if (take) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_byte_r[i] <= line_byte_nxt[i];
        line_tag_r[i]  <= line_tag_nxt[i];
      end
      cur_cls_r  <= cur_cls_nxt;
      zero_run_r <= zero_run_nxt;
      pending_r  <= pending_nxt;
      holdoff_r  <= holdoff_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // Type code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_code_r <= SPS_CODE_RESET;
      pps_code_r <= PPS_CODE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPS_CODE: sps_code_r <= cfg_data;
        REG_PPS_CODE: pps_code_r <= cfg_data;
        default:      sps_code_r <= sps_code_r;
      endcase
    end
  end

endmodule

// ----- rtl/h264pse_result_fifo.sv -----
// Result queue: packs the valid candidates of an item and hands them out one per cycle while pop is high.
module h264pse_result_fifo
  import h264pse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  cand_t [NUM_CAND-1:0]  cand_i,
  input  logic                  pop,
  output res_t                  head_o,
  output logic                  not_empty_o,
  output logic                  room_o
);

  res_t             entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             room_r;

  logic [PTR_W-1:0] addr [NUM_CAND];
  logic [CNT_W-1:0] n_new;
  logic [CNT_W-1:0] n_add;
  logic [CNT_W-1:0] count_nxt;

  // Place each valid candidate right after the previous one
  always_comb begin
    n_new = '0;
    for (int k = 0; k < NUM_CAND; k++) begin
      addr[k] = wr_ptr_r + n_new[PTR_W-1:0];
      if (cand_i[k].valid) begin
        n_new = n_new + CNT_W'(1);
      end
    end
    n_add     = wr_en ? n_new : '0;
    count_nxt = count_r + n_add - (pop ? CNT_W'(1) : CNT_W'(0));
  end

  // Store results
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < NUM_CAND; k++) begin
        if (cand_i[k].valid) begin
          entry_r[addr[k]] <= res_t'{data: cand_i[k].data, pps: cand_i[k].pps,
                                     first: cand_i[k].first, last: cand_i[k].last};
        end
      end
    end
  end

  // Pointers, fill count and input room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      room_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_add[PTR_W-1:0];
      rd_ptr_r <= rd_ptr_r + (pop ? PTR_W'(1) : PTR_W'(0));
      count_r  <= count_nxt;
      room_r   <= (count_nxt <= CNT_W'(READY_LIMIT));
    end
  end

  assign head_o      = entry_r[rd_ptr_r];
  assign not_empty_o = (count_r != '0);
  assign room_o      = room_r;

endmodule

// ----- rtl/h264_parameter_set_extractor_core.sv -----
// The results of an item are written into the result queue as the item is accepted.
// Throughput: one item per cycle while in_ready is high; an end-of-buffer item flushes up
// to six results, drained from an eight-entry result queue one per cycle while out_ready is high.
// Input is taken while the queue holds two results or fewer, so a full flush always fits.
// Reset (rst_n low, synchronous) empties the line and queue, sets type codes to 7 and 8.
// Top level of the H.264 parameter set extractor.
module h264_parameter_set_extractor_core
  import h264pse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_unit_class,
  output logic       out_unit_first,
  output logic       out_run_last,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

  cand_t [NUM_CAND-1:0] cand;
  res_t                 head;
  logic                 take;
  logic                 pop;

  assign take = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  h264pse_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .stream_byte   (in_stream_byte),
    .end_of_buffer (in_end_of_buffer),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cand_o        (cand)
  );

  h264pse_result_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (take),
    .cand_i      (cand),
    .pop         (pop),
    .head_o      (head),
    .not_empty_o (out_valid),
    .room_o      (in_ready)
  );

  assign out_byte       = head.data;
  assign out_unit_class = head.pps;
  assign out_unit_first = head.first;
  assign out_run_last   = head.last;

endmodule

// ----- rtl/h264pse_checker.sv -----
// Port-level checks of the extractor, bound to the top level.
module h264pse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_stream_byte,
  input logic       in_end_of_buffer,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_unit_class,
  input logic       out_unit_first,
  input logic       out_run_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_unit_class) && $stable(out_unit_first) && $stable(out_run_last))
    else $error("stalled result changed");

  // Reset empties the queue and blocks input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("not idle after reset");

  // Results only appear after an accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an item");

  // Input is refused only while results wait, apart from the first cycle after reset
  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid || !$past(rst_n))
    else $error("input blocked with an empty queue");

  // A waiting item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_stream_byte) &&
      $stable(in_end_of_buffer))
    else $error("waiting item changed");

endmodule

bind h264_parameter_set_extractor_core h264pse_checker u_h264pse_checker (.*);
